/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: ante implies cons");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: ante implies cons next cycle");

`endif

/* src/msfc_pkg.sv */
// ----------------------------------------------------------------------------
// msfc_pkg
// shared constants, types and codes of the meter-style frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package msfc_pkg;

	localparam int KeepBytes     = 18;
	localparam int RxBufferBytes = 64;
	localparam int PosW          = 8;
	localparam int IdxW          = $clog2(KeepBytes);
	localparam int SumShortBytes = 14;
	localparam int SumWriteBytes = 16;
	localparam int CfgIdxW       = 3;
	localparam int CfgDataW      = 48;

	localparam logic [7:0] START_BYTE  = 8'h68;
	localparam logic [7:0] STOP_BYTE   = 8'h16;
	localparam logic [7:0] CTRL_READ   = 8'h11;
	localparam logic [7:0] CTRL_WRITE  = 8'h14;
	localparam logic [7:0] LEN_SHORT   = 8'h04;
	localparam logic [7:0] LEN_WRITE   = 8'h06;
	localparam logic [7:0] DI0_BYTE    = 8'h00;
	localparam logic [7:0] DI1_BYTE    = 8'h02;
	localparam logic [7:0] DI3_BYTE    = 8'h84;
	localparam logic [7:0] ID_PING     = 8'h00;
	localparam logic [7:0] ID_STATE    = 8'h0A;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_STATION_ADDRESS,
		CFG_SWITCH_OPEN,
		CFG_SWITCH_CLOSE,
		CFG_MOVE_UP,
		CFG_MOVE_STOP,
		CFG_MOVE_DOWN,
		CFG_MOVE_LIFT
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_INVALID,
		KIND_PING,
		KIND_READ_STATE,
		KIND_WRITE_CONTROL
	} frame_kind_t;

	typedef logic [KeepBytes-1:0][7:0] frame_t;

	typedef struct packed {
		logic [47:0] station_address;
		logic [7:0]  switch_open;
		logic [7:0]  switch_close;
		logic [7:0]  move_up;
		logic [7:0]  move_stop;
		logic [7:0]  move_down;
		logic [7:0]  move_lift;
	} cfg_t;

	typedef struct packed {
		frame_t     frame;
		logic [7:0] sum_short;
		logic [7:0] sum_write;
	} store_view_t;

	typedef struct packed {
		frame_kind_t kind;
		logic [7:0]  switch_code;
		logic [7:0]  move_code;
	} result_t;

endpackage

`default_nettype wire

/* src/msfc_frame_store.sv */
// ----------------------------------------------------------------------------
// msfc_frame_store
// keeps the first bytes of a frame, running checksums and the byte position;
// presents the frame with the pending word merged in
// ----------------------------------------------------------------------------
`default_nettype none

module msfc_frame_store import msfc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [7:0]  byte_s1,
	input  wire logic        eof_s1,
	output store_view_t      view,
	output logic [PosW-1:0]  position
);

	frame_t          frame_q;
	logic [7:0]      sum_short_q;
	logic [7:0]      sum_write_q;
	logic [PosW-1:0] pos_q;
	logic            hit;

	always_comb begin
		view.frame = frame_q;
		hit = pos_q < PosW'(KeepBytes);
		if (hit) begin
			view.frame[pos_q[IdxW-1:0]] = byte_s1;
		end
		view.sum_short = sum_short_q + ((pos_q < PosW'(SumShortBytes)) ? byte_s1 : 8'h00);
		view.sum_write = sum_write_q + ((pos_q < PosW'(SumWriteBytes)) ? byte_s1 : 8'h00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= '0;
			sum_short_q <= '0;
			sum_write_q <= '0;
			pos_q       <= '0;
		end else if (advance) begin
			if (eof_s1) begin
				frame_q     <= '0;
				sum_short_q <= '0;
				sum_write_q <= '0;
				pos_q       <= '0;
			end else begin
				frame_q     <= view.frame;
				sum_short_q <= view.sum_short;
				sum_write_q <= view.sum_write;
				if (pos_q < PosW'(RxBufferBytes)) begin
					pos_q <= pos_q + PosW'(1);
				end
			end
		end
	end

	assign position = pos_q;

endmodule

`default_nettype wire

/* src/msfc_classify.sv */
// ----------------------------------------------------------------------------
// msfc_classify
// classifies a complete frame as invalid, ping, read-state or write-control
// ----------------------------------------------------------------------------
`default_nettype none

module msfc_classify import msfc_pkg::*; (
	input  wire store_view_t view,
	input  wire cfg_t        cfg,
	output result_t          result
);

	frame_t f;
	logic   addr_ok;
	logic   common_ok;
	logic   short_ok;
	logic   ping_ok;
	logic   state_ok;
	logic   sw_ok;
	logic   mv_ok;
	logic   write_ok;

	always_comb begin
		f = view.frame;
		addr_ok = 1'b1;
		for (int i = 0; i < 6; i++) begin
			if (f[1 + i] != cfg.station_address[8*i +: 8]) begin
				addr_ok = 1'b0;
			end
		end
		common_ok = (f[0] == START_BYTE) && addr_ok && (f[7] == START_BYTE)
			&& (f[10] == DI0_BYTE) && (f[11] == DI1_BYTE) && (f[13] == DI3_BYTE);
		short_ok = common_ok && (f[8] == CTRL_READ) && (f[9] == LEN_SHORT)
			&& (f[14] == view.sum_short) && (f[15] == STOP_BYTE);
		ping_ok  = short_ok && (f[12] == ID_PING);
		state_ok = short_ok && (f[12] == ID_STATE);
		sw_ok = (f[14] == cfg.switch_open) || (f[14] == cfg.switch_close);
		mv_ok = (f[15] == cfg.move_up) || (f[15] == cfg.move_stop)
			|| (f[15] == cfg.move_down) || (f[15] == cfg.move_lift);
		write_ok = common_ok && (f[8] == CTRL_WRITE) && (f[9] == LEN_WRITE)
			&& (f[12] == ID_STATE) && sw_ok && mv_ok
			&& (f[16] == view.sum_write) && (f[17] == STOP_BYTE);

		result.kind        = KIND_INVALID;
		result.switch_code = 8'h00;
		result.move_code   = 8'h00;
		if (ping_ok) begin
			result.kind = KIND_PING;
		end else if (state_ok) begin
			result.kind = KIND_READ_STATE;
		end else if (write_ok) begin
			result.kind        = KIND_WRITE_CONTROL;
			result.switch_code = f[14];
			result.move_code   = f[15];
		end
	end

endmodule

`default_nettype wire

/* src/meter_style_frame_checker_core.sv */
// a frame's result is registered in the result register when its last word advances out of the input register
// throughput: one word per cycle unless the input register stalls; a new word is taken while a result waits
// the input register stalls only on a last word while the result register is full and out_ready is low
// reset: arst_n low clears the frame store, position, pipeline valids and
//   loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// meter_style_frame_checker_core
// top level: input register, frame store, classifier, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module meter_style_frame_checker_core import msfc_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                end_of_frame,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               frame_kind,
	output logic [7:0]               switch_code,
	output logic [7:0]               move_code
);

	cfg_t            cfg_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eof_s1;
	logic            advance;
	store_view_t     view;
	logic [PosW-1:0] position;
	result_t         result;
	logic            out_valid_q;
	result_t         result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.station_address <= '0;
			cfg_q.switch_open     <= 8'h01;
			cfg_q.switch_close    <= 8'h00;
			cfg_q.move_up         <= 8'h00;
			cfg_q.move_stop       <= 8'h01;
			cfg_q.move_down       <= 8'h02;
			cfg_q.move_lift       <= 8'h03;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_STATION_ADDRESS: cfg_q.station_address <= cfg_wdata[47:0];
				CFG_SWITCH_OPEN:     cfg_q.switch_open     <= cfg_wdata[7:0];
				CFG_SWITCH_CLOSE:    cfg_q.switch_close    <= cfg_wdata[7:0];
				CFG_MOVE_UP:         cfg_q.move_up         <= cfg_wdata[7:0];
				CFG_MOVE_STOP:       cfg_q.move_stop       <= cfg_wdata[7:0];
				CFG_MOVE_DOWN:       cfg_q.move_down       <= cfg_wdata[7:0];
				CFG_MOVE_LIFT:       cfg_q.move_lift       <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!eof_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			eof_s1   <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				eof_s1 <= end_of_frame;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	msfc_frame_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.eof_s1   (eof_s1),
		.view     (view),
		.position (position)
	);

	msfc_classify u_classify (
		.view   (view),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eof_s1) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_kind  = result_q.kind;
	assign switch_code = result_q.switch_code;
	assign move_code   = result_q.move_code;

	`ASSERT_IMPL(a_codes_only_for_write, out_valid_q && (result_q.kind != KIND_WRITE_CONTROL), (result_q.switch_code == 8'h00) && (result_q.move_code == 8'h00))
	`ASSERT_NEXT(a_position_cleared_at_end, advance && eof_s1, position == '0)
	`ASSERT_IMPL(a_stall_only_when_held, !in_ready, valid_s1 && eof_s1 && out_valid_q)
	`ASSERT_IMPL(a_position_saturates, 1'b1, position <= PosW'(RxBufferBytes))

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for meter_style_frame_checker_core: frames of every kind,
// short, long and corrupted ones are fed word by word under random bursts and
// output stalls; a behavioral frame classifier predicts each frame-end result
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import msfc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ResultLatency = 2;
	localparam int SettleCycles  = ResultLatency + 4;
	localparam int HoldCycles    = 400;
	localparam int PhaseWords    = 300;
	localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 3'd7;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index    = '0;
	logic [CfgDataW-1:0] cfg_wdata    = '0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [7:0]          rx_byte      = 8'h00;
	logic                end_of_frame = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [1:0]          frame_kind;
	logic [7:0]          switch_code;
	logic [7:0]          move_code;

	meter_style_frame_checker_core dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.in_valid,
		.in_ready,
		.rx_byte,
		.end_of_frame,
		.out_valid,
		.out_ready,
		.frame_kind,
		.switch_code,
		.move_code
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// classifier copy of the block
	cfg_t       setup;
	logic [7:0] frame_img [KeepBytes];
	logic [7:0] fill_pos;
	result_t    due_results [$];

	logic [7:0] frame_buf [$];
	int         errors     = 0;
	int         words_sent = 0;
	int         burst_left = 0;
	bit         steady     = 1'b0;
	bit         hold_req   = 1'b0;
	result_t    want;

	function automatic logic [7:0] img_sum(int count);
		logic [7:0] s;
		s = 8'h00;
		for (int i = 0; i < count; i++)
			s = s + frame_img[i];
		return s;
	endfunction

	function automatic bit header_good(logic [7:0] ctrl, logic [7:0] len, logic [7:0] id);
		if (frame_img[0] != START_BYTE || frame_img[7] != START_BYTE)
			return 1'b0;
		for (int i = 0; i < 6; i++)
			if (frame_img[1 + i] != setup.station_address[8 * i +: 8])
				return 1'b0;
		return frame_img[8] == ctrl && frame_img[9] == len && frame_img[10] == DI0_BYTE &&
			frame_img[11] == DI1_BYTE && frame_img[12] == id && frame_img[13] == DI3_BYTE;
	endfunction

	function automatic bit query_good(logic [7:0] id);
		return header_good(CTRL_READ, LEN_SHORT, id) && frame_img[14] == img_sum(14) &&
			frame_img[15] == STOP_BYTE;
	endfunction

	function automatic bit command_good();
		logic [7:0] sw;
		logic [7:0] mv;
		sw = frame_img[14];
		mv = frame_img[15];
		if (!header_good(CTRL_WRITE, LEN_WRITE, ID_STATE))
			return 1'b0;
		if (sw != setup.switch_open && sw != setup.switch_close)
			return 1'b0;
		if (mv != setup.move_up && mv != setup.move_stop && mv != setup.move_down &&
				mv != setup.move_lift)
			return 1'b0;
		return frame_img[16] == img_sum(16) && frame_img[17] == STOP_BYTE;
	endfunction

	function automatic void track_word(logic [7:0] b, logic last);
		result_t r;
		if (fill_pos < KeepBytes)
			frame_img[fill_pos] = b;
		if (fill_pos < RxBufferBytes)
			fill_pos = fill_pos + 8'd1;
		if (!last)
			return;
		r.kind        = KIND_INVALID;
		r.switch_code = 8'h00;
		r.move_code   = 8'h00;
		if (query_good(ID_PING)) begin
			r.kind = KIND_PING;
		end else if (query_good(ID_STATE)) begin
			r.kind = KIND_READ_STATE;
		end else if (command_good()) begin
			r.kind        = KIND_WRITE_CONTROL;
			r.switch_code = frame_img[14];
			r.move_code   = frame_img[15];
		end
		due_results.push_back(r);
		fill_pos = 8'd0;
		foreach (frame_img[i])
			frame_img[i] = 8'h00;
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_STATION_ADDRESS: setup.station_address = val;
			CFG_SWITCH_OPEN:     setup.switch_open     = val[7:0];
			CFG_SWITCH_CLOSE:    setup.switch_close    = val[7:0];
			CFG_MOVE_UP:         setup.move_up         = val[7:0];
			CFG_MOVE_STOP:       setup.move_stop       = val[7:0];
			CFG_MOVE_DOWN:       setup.move_down       = val[7:0];
			CFG_MOVE_LIFT:       setup.move_lift       = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// byte registers ignore the upper data bits
	function automatic logic [CfgDataW-1:0] code_word(logic [7:0] code);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return {r[39:0], code};
	endfunction

	task automatic write_codes(input logic [7:0] op, input logic [7:0] cl, input logic [7:0] up,
			input logic [7:0] st, input logic [7:0] dn, input logic [7:0] lf);
		write_reg(CFG_SWITCH_OPEN, code_word(op));
		write_reg(CFG_SWITCH_CLOSE, code_word(cl));
		write_reg(CFG_MOVE_UP, code_word(up));
		write_reg(CFG_MOVE_STOP, code_word(st));
		write_reg(CFG_MOVE_DOWN, code_word(dn));
		write_reg(CFG_MOVE_LIFT, code_word(lf));
	endtask

	task automatic send_word(input logic [7:0] b, input logic last);
		bit took;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		rx_byte      <= b;
		end_of_frame <= last;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end
		track_word(b, last);
		words_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_word(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic wait_idle();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (due_results.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (due_results.size() != 0) begin
			errors++;
			$display("%0t: %0d frame results never arrived", $time, due_results.size());
			due_results.delete();
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic seal_frame();
		logic [7:0] s;
		s = 8'h00;
		foreach (frame_buf[i])
			s = s + frame_buf[i];
		frame_buf.push_back(s);
		frame_buf.push_back(STOP_BYTE);
	endtask

	task automatic add_noise(input int count);
		repeat (count) frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic make_frame(input frame_kind_t kind);
		logic [7:0] mv;
		frame_buf.delete();
		if (kind == KIND_INVALID) begin
			add_noise($urandom_range(1, 24));
			if ($urandom_range(0, 1))
				frame_buf[0] = START_BYTE;
			return;
		end
		frame_buf.push_back(START_BYTE);
		for (int i = 0; i < 6; i++)
			frame_buf.push_back(setup.station_address[8 * i +: 8]);
		frame_buf.push_back(START_BYTE);
		frame_buf.push_back(kind == KIND_WRITE_CONTROL ? CTRL_WRITE : CTRL_READ);
		frame_buf.push_back(kind == KIND_WRITE_CONTROL ? LEN_WRITE : LEN_SHORT);
		frame_buf.push_back(DI0_BYTE);
		frame_buf.push_back(DI1_BYTE);
		frame_buf.push_back(kind == KIND_PING ? ID_PING : ID_STATE);
		frame_buf.push_back(DI3_BYTE);
		if (kind == KIND_WRITE_CONTROL) begin
			frame_buf.push_back($urandom_range(0, 1) ? setup.switch_open : setup.switch_close);
			case ($urandom_range(0, 3))
				0: mv = setup.move_up;
				1: mv = setup.move_stop;
				2: mv = setup.move_down;
				default: mv = setup.move_lift;
			endcase
			frame_buf.push_back(mv);
		end
		seal_frame();
	endtask

	task automatic random_frame();
		int r;
		int idx;
		make_frame(frame_kind_t'($urandom_range(1, 3)));
		r = $urandom_range(0, 99);
		if (r < 15) begin
			idx = $urandom_range(0, frame_buf.size() - 1);
			frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
		end else if (r < 23) begin
			idx = $urandom_range(1, frame_buf.size() - 1);
			while (frame_buf.size() > idx)
				void'(frame_buf.pop_back());
		end else if (r < 31) begin
			add_noise($urandom_range(1, 8));
		end else if (r < 38) begin
			make_frame(KIND_INVALID);
		end else if (r < 43 && frame_buf.size() == KeepBytes) begin
			// checksum kept right, switch or move code arbitrary
			void'(frame_buf.pop_back());
			void'(frame_buf.pop_back());
			frame_buf[$urandom_range(14, 15)] = 8'($urandom_range(0, 255));
			seal_frame();
		end else if (r < 45) begin
			add_noise($urandom_range(47, 70));
		end
		send_frame();
	endtask

	task automatic test_default_setup();
		make_frame(KIND_PING);
		send_frame();
		make_frame(KIND_READ_STATE);
		send_frame();
		make_frame(KIND_WRITE_CONTROL);
		send_frame();
		wait_idle();
	endtask

	task automatic test_short_frames();
		send_word(8'hFF, 1'b1);
		send_word(START_BYTE, 1'b1);
		// stop byte missing, reads as zero
		make_frame(KIND_PING);
		void'(frame_buf.pop_back());
		send_frame();
		make_frame(KIND_WRITE_CONTROL);
		void'(frame_buf.pop_back());
		send_frame();
		wait_idle();
	endtask

	task automatic test_long_frame();
		make_frame(KIND_WRITE_CONTROL);
		add_noise(60);
		send_frame();
		make_frame(KIND_READ_STATE);
		add_noise(2);
		send_frame();
		make_frame(KIND_PING);
		send_frame();
		wait_idle();
	endtask

	task automatic test_register_map();
		write_reg(CFG_UNMAPPED, CfgDataW'({$urandom, $urandom}));
		make_frame(KIND_PING);
		send_frame();
		wait_idle();
		write_reg(CFG_STATION_ADDRESS, '1);
		write_codes(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F);
		make_frame(KIND_WRITE_CONTROL);
		send_frame();
		make_frame(KIND_READ_STATE);
		send_frame();
		wait_idle();
	endtask

	task automatic load_setup(input int style);
		logic [63:0] a;
		a = {$urandom, $urandom};
		case (style)
			0: begin
				write_reg(CFG_STATION_ADDRESS, '0);
				write_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			end
			1: begin
				write_reg(CFG_STATION_ADDRESS, 48'h68_16_00_FF_84_0A);
				write_codes(8'hFF, 8'h01, 8'hFF, 8'hFE, 8'h16, 8'h68);
			end
			default: begin
				write_reg(CFG_STATION_ADDRESS, a[47:0]);
				write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		endcase
		write_reg(CFG_UNMAPPED, CfgDataW'({$urandom, $urandom}));
	endtask

	task automatic test_random_traffic();
		int quota;
		for (int phase = 0; phase < 5; phase++) begin
			load_setup(phase);
			quota = words_sent + PhaseWords;
			while (words_sent < quota) begin
				steady = ($urandom_range(0, 4) == 0);
				random_frame();
			end
			steady = 1'b0;
			wait_idle();
		end
	endtask

	task automatic test_output_backpressure();
		hold_req = 1'b1;
		steady   = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word(8'($urandom_range(0, 255)), i == 39 || $urandom_range(0, 1));
		make_frame(KIND_WRITE_CONTROL);
		send_frame();
		steady = 1'b0;
		wait_idle();
	endtask

	initial begin : receiver_pattern
		int mode;
		int left;
		int hold;
		bit held;
		mode = 0;
		left = 0;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				hold = HoldCycles;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(32, 256);
			end
			left--;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (left % 3 == 0);
				endcase
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, frame_kind %0d switch %h move %h",
					$time, frame_kind, switch_code, move_code);
			end else begin
				want = due_results.pop_front();
				if (frame_kind !== want.kind) begin
					errors++;
					$display("%0t: frame_kind expected %0d actual %0d",
						$time, want.kind, frame_kind);
				end
				if (switch_code !== want.switch_code) begin
					errors++;
					$display("%0t: switch_code expected %h actual %h",
						$time, want.switch_code, switch_code);
				end
				if (move_code !== want.move_code) begin
					errors++;
					$display("%0t: move_code expected %h actual %h",
						$time, want.move_code, move_code);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		setup.station_address = '0;
		setup.switch_open     = 8'd1;
		setup.switch_close    = 8'd0;
		setup.move_up         = 8'd0;
		setup.move_stop       = 8'd1;
		setup.move_down       = 8'd2;
		setup.move_lift       = 8'd3;
		fill_pos = 8'd0;
		foreach (frame_img[i])
			frame_img[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_setup();
		test_short_frames();
		test_long_frame();
		test_register_map();
		test_random_traffic();
		test_output_backpressure();
		wait_idle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+src
src/msfc_pkg.sv
src/msfc_frame_store.sv
src/msfc_classify.sv
src/meter_style_frame_checker_core.sv
tb/testbench.sv
